### src/source_line_sanitizer_unit_macros.svh
// Assertion macros shared by the source line sanitizer RTL.
`ifndef SOURCE_LINE_SANITIZER_UNIT_MACROS_SVH
`define SOURCE_LINE_SANITIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define SLS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("source line sanitizer: assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SLS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("source line sanitizer: assertion failed");
`else
`define SLS_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SLS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### src/sls_pkg.sv
// Types and constants for the source line sanitizer.
package sls_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // Characters with a special meaning.
   localparam logic [7:0] CHAR_GT     = 8'h3E;
   localparam logic [7:0] CHAR_LT     = 8'h3C;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SEMI   = 8'h3B;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // Configuration default.
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

   // Result queue geometry; one item gives at most three results.
   localparam int FIFO_DEPTH  = 4;
   localparam int MAX_PUSH    = 3;
   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   // One result transaction.
   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_char;
      logic       line_done;
      logic       line_ok;
      logic       last;
   } rsp_entry_type;

endpackage

### src/source_line_sanitizer_unit.sv
// Source line sanitizer: comment removal, quote passthrough, whitespace cleanup.
//
// Usage: the request channel carries one transaction per input byte
// (req_kind = 0, byte on req_char_in) or an end-of-line marker
// (req_kind = 1). The response channel returns cleaned bytes and, for each
// end-of-line marker, a closing status transaction with rsp_line_done and
// rsp_line_ok; rsp_last marks the final response caused by a request.
// A byte request gives at most one response, an end-of-line request up to
// three (two bytes and the status).
// Responses for a request are in the result queue in the cycle after
// acceptance; because of the one-byte lookahead and the held-back output
// byte, a character shows up only once later requests push it out.
// Throughput: one request per cycle while the receiver keeps up. The four
// entry result queue drains one response per cycle and must have room for
// three entries, so after an end-of-line request req_stall stays high while
// the extra responses drain.
// Reset clears all line and comment state, empties the result queue and
// sets max_length to 256. When the receiver raises rsp_stall the queue
// holds its head entry steady and fills; req_stall then rises from the
// registered fill level. max_length is written through csr_wr_en/csr_wr_data.
`include "source_line_sanitizer_unit_macros.svh"

module source_line_sanitizer_unit
   import sls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration write
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_char_in,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_line_done,
   output logic        rsp_line_ok,
   output logic        rsp_last
);

   // Line state registers.
   logic [15:0] max_len_ff;
   logic        comment_ff, comment_in;
   logic        quote_ff, quote_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [15:0] out_count_ff, out_count_in;
   logic        trunc_ff, trunc_in;

   // Result queue.
   rsp_entry_type          fifo_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   // Combinational working signals.
   logic          accept;
   logic          pop;
   logic          is_eol;
   logic [15:0]   limit;
   logic          run;
   logic          emit_en;
   logic [7:0]    emit_byte;
   logic          both;
   logic          set_trunc;
   logic          comment_p;
   logic          quote_p;
   logic          rel_en;
   logic [7:0]    held_b1;
   logic          held_v1;
   logic [15:0]   count1;
   logic [7:0]    prev1;
   logic          flush_en;
   logic          line_empty;
   logic [7:0]    last_byte;
   logic          line_ok;
   rsp_entry_type cand [MAX_PUSH];
   logic          cand_v [MAX_PUSH];
   rsp_entry_type push_data [MAX_PUSH];
   logic [1:0]    push_num;

   // Whitespace is tab through carriage return, or space.
   function automatic logic is_ws(input logic [7:0] c);
      is_ws = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign is_eol    = (req_kind == KIND_EOL);
   assign req_stall = (count_ff > COUNT_WIDTH'(FIFO_DEPTH - MAX_PUSH));

   // Process the pending byte with the incoming byte as lookahead.
   always_comb begin
      limit     = (max_len_ff > 16'd2) ? (max_len_ff - 16'd2) : '0;
      run       = accept && pend_valid_ff && !trunc_ff &&
                  (is_eol || (req_char_in != 8'd0));
      emit_en   = 1'b0;
      emit_byte = '0;
      both      = 1'b0;
      set_trunc = 1'b0;
      comment_p = comment_ff;
      quote_p   = quote_ff;
      if (run) begin
         if (out_count_ff >= limit) begin
            set_trunc = 1'b1;
         end else if (!quote_ff && !comment_ff && pend_byte_ff == CHAR_GT &&
                      !is_eol && req_char_in == CHAR_GT) begin
            comment_p = 1'b1;
            both      = 1'b1;
         end else if (!quote_ff && comment_ff && pend_byte_ff == CHAR_LT &&
                      !is_eol && req_char_in == CHAR_LT) begin
            comment_p = 1'b0;
            both      = 1'b1;
         end else if (!comment_ff) begin
            if (pend_byte_ff == CHAR_DQUOTE) begin
               quote_p   = !quote_ff;
               emit_en   = 1'b1;
               emit_byte = pend_byte_ff;
            end else if (quote_ff) begin
               emit_en   = 1'b1;
               emit_byte = pend_byte_ff;
            end else if (is_ws(pend_byte_ff)) begin
               // Collapse whitespace; never at line start, end or after a space.
               if (out_count_ff != 16'd0 && held_valid_ff &&
                   held_byte_ff != CHAR_SPACE && !is_eol && !is_ws(req_char_in)) begin
                  emit_en   = 1'b1;
                  emit_byte = CHAR_SPACE;
               end
            end else begin
               emit_en   = 1'b1;
               emit_byte = pend_byte_ff;
            end
         end
      end

      // An emitted byte releases the held byte and takes its place.
      rel_en  = emit_en && held_valid_ff;
      held_b1 = emit_en ? emit_byte : held_byte_ff;
      held_v1 = emit_en || held_valid_ff;
      count1  = emit_en ? (out_count_ff + 16'd1) : out_count_ff;
      prev1   = rel_en ? held_byte_ff : prev_byte_ff;
   end

   // Next state and line closing status.
   always_comb begin
      comment_in    = comment_ff;
      quote_in      = quote_ff;
      pend_byte_in  = pend_byte_ff;
      pend_valid_in = pend_valid_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      prev_byte_in  = prev_byte_ff;
      out_count_in  = out_count_ff;
      trunc_in      = trunc_ff;
      flush_en      = 1'b0;
      line_empty    = 1'b1;
      last_byte     = '0;
      line_ok       = 1'b0;
      if (accept) begin
         if (!is_eol) begin
            // Zero bytes and bytes after truncation are ignored.
            if (req_char_in != 8'd0 && !trunc_ff) begin
               comment_in    = comment_p;
               quote_in      = quote_p;
               held_byte_in  = held_b1;
               held_valid_in = held_v1;
               prev_byte_in  = prev1;
               out_count_in  = count1;
               trunc_in      = set_trunc;
               if (pend_valid_ff && (set_trunc || both)) begin
                  pend_valid_in = 1'b0;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_byte_in  = req_char_in;
               end
            end
         end else begin
            // Flush the held byte unless it is a trailing space.
            flush_en = held_v1 && (held_b1 != CHAR_SPACE);
            if (!held_v1) begin
               line_empty = 1'b1;
               last_byte  = '0;
            end else if (held_b1 != CHAR_SPACE) begin
               line_empty = 1'b0;
               last_byte  = held_b1;
            end else begin
               line_empty = (count1 < 16'd2);
               last_byte  = prev1;
            end
            line_ok       = line_empty || (last_byte == CHAR_SEMI);
            comment_in    = comment_p;
            prev_byte_in  = flush_en ? held_b1 : prev1;
            quote_in      = 1'b0;
            held_valid_in = 1'b0;
            out_count_in  = '0;
            trunc_in      = 1'b0;
            pend_valid_in = 1'b0;
         end
      end
   end

   // Candidate responses in order, then packed into consecutive slots.
   always_comb begin
      cand[0]   = '{out_valid: 1'b1, out_char: held_byte_ff, line_done: 1'b0,
                    line_ok: 1'b0, last: !is_eol};
      cand[1]   = '{out_valid: 1'b1, out_char: held_b1, line_done: 1'b0,
                    line_ok: 1'b0, last: 1'b0};
      cand[2]   = '{out_valid: 1'b0, out_char: 8'd0, line_done: 1'b1,
                    line_ok: line_ok, last: 1'b1};
      cand_v[0] = rel_en;
      cand_v[1] = accept && is_eol && flush_en;
      cand_v[2] = accept && is_eol;

      push_data[0] = cand_v[0] ? cand[0] : (cand_v[1] ? cand[1] : cand[2]);
      push_data[1] = (cand_v[0] && cand_v[1]) ? cand[1] : cand[2];
      push_data[2] = cand[2];
      push_num     = 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]);

      wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push_num);
      rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
      count_in  = count_ff + COUNT_WIDTH'(push_num) - COUNT_WIDTH'(pop);
   end

   // Control and line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= MAX_LENGTH_RESET;
         comment_ff    <= 1'b0;
         quote_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         prev_byte_ff  <= '0;
         out_count_ff  <= '0;
         trunc_ff      <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         comment_ff    <= comment_in;
         quote_ff      <= quote_in;
         pend_valid_ff <= pend_valid_in;
         held_valid_ff <= held_valid_in;
         prev_byte_ff  <= prev_byte_in;
         out_count_ff  <= out_count_in;
         trunc_ff      <= trunc_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Payload registers and result queue storage.
   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      held_byte_ff <= held_byte_in;
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push_num) begin
            fifo_ff[wr_ptr_ff + PTR_WIDTH'(i)] <= push_data[i];
         end
      end
   end

   // Head of the result queue drives the response channel.
   assign rsp_valid     = (count_ff != '0);
   assign rsp_out_valid = fifo_ff[rd_ptr_ff].out_valid;
   assign rsp_out_char  = fifo_ff[rd_ptr_ff].out_char;
   assign rsp_line_done = fifo_ff[rd_ptr_ff].line_done;
   assign rsp_line_ok   = fifo_ff[rd_ptr_ff].line_ok;
   assign rsp_last      = fifo_ff[rd_ptr_ff].last;

   // The queue never holds more entries than it has.
   `SLS_ASSERT_IMPLY(a_fifo_bound, clock, reset, 1'b1, count_ff <= COUNT_WIDTH'(FIFO_DEPTH))
   // A status transaction carries no byte and closes its request.
   `SLS_ASSERT_IMPLY(a_status_last, clock, reset, rsp_valid && rsp_line_done, rsp_last && !rsp_out_valid)
   // An end-of-line transaction leaves a clean line state behind.
   `SLS_ASSERT_NEXT(a_eol_clears, clock, reset, accept && is_eol, !held_valid_ff && !pend_valid_ff && !trunc_ff && out_count_ff == '0)
   // A held byte always counts as output of the current line.
   `SLS_ASSERT_IMPLY(a_held_counted, clock, reset, held_valid_ff, out_count_ff != '0)
   // Truncation discards the lookahead byte.
   `SLS_ASSERT_IMPLY(a_trunc_no_pend, clock, reset, trunc_ff, !pend_valid_ff)

endmodule
